// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the scanner RTL.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/adrp_xref_pkg.sv =====
// ----------------------------------------------------------------------------
// adrp_xref_pkg
// Shared types, constants and instruction decode helpers for the ADRP scanner.
// ----------------------------------------------------------------------------
package adrp_xref_pkg;

    localparam int ADDR_W  = 64;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 31;
    localparam int LIMIT_W = 16;
    localparam int KIND_W  = 2;
    localparam int PAGE_W  = 12;
    localparam int IMM21_W = 21;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    // output queue depth, a power of two of at least 2
    localparam int OUTQ_DEPTH = 4;

    localparam logic [WORD_W-1:0] ADRP_MASK = 32'h9F00_0000;
    localparam logic [WORD_W-1:0] ADRP_OPC  = 32'h9000_0000;
    localparam logic [WORD_W-1:0] ADDI_MASK = 32'h7F00_0000;
    localparam logic [WORD_W-1:0] ADDI_OPC  = 32'h1100_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_MATCH = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } result_t;

    // Stage register between item capture and match evaluation
    typedef struct packed {
        logic               present;
        logic               last;
        logic               aligned;
        logic               mode;
        logic [WORD_W-1:0]  adrp_word;
        logic               pair_ok;
        logic [ADDR_W-1:0]  adrp_pc;
        logic [ADDR_W-1:0]  cmp_value;
    } stage_t;

    function automatic logic is_adrp(input logic [WORD_W-1:0] w);
        return (w & ADRP_MASK) == ADRP_OPC;
    endfunction

    // Signed 21-bit page immediate of an ADRP: immhi then immlo
    function automatic logic [IMM21_W-1:0] adrp_imm(input logic [WORD_W-1:0] w);
        return {w[23:5], w[30:29]};
    endfunction

    // 64-bit ADD immediate, shift 0 or 12, with Rd and Rn equal to the ADRP's Rd
    function automatic logic add_pair_ok(input logic [WORD_W-1:0] adrp,
                                         input logic [WORD_W-1:0] a);
        return ((a & ADDI_MASK) == ADDI_OPC) && a[31] && !a[23]
            && (a[4:0] == adrp[4:0]) && (a[9:5] == adrp[4:0]);
    endfunction

    function automatic logic [ADDR_W-1:0] add_imm(input logic [WORD_W-1:0] a);
        logic [ADDR_W-1:0] imm;
        imm = {{(ADDR_W-12){1'b0}}, a[21:10]};
        if (a[22])
        begin
            imm = {{(ADDR_W-24){1'b0}}, a[21:10], 12'h000};
        end
        return imm;
    endfunction

endpackage

// ===== rtl/adrp_xref_match.sv =====
// ----------------------------------------------------------------------------
// adrp_xref_match
// Forms the ADRP page of a staged item and compares it with the target.
// ----------------------------------------------------------------------------
module adrp_xref_match (
    input  adrp_xref_pkg::stage_t stage,
    output logic                  hit
);
    import adrp_xref_pkg::*;

    localparam int HI_W = ADDR_W - PAGE_W;

    logic [IMM21_W-1:0] imm;
    logic [HI_W-1:0]    page_hi;
    logic [ADDR_W-1:0]  page;
    logic               same;

    always_comb
    begin
        imm     = adrp_imm(stage.adrp_word);
        page_hi = stage.adrp_pc[ADDR_W-1:PAGE_W]
                + {{(HI_W-IMM21_W){imm[IMM21_W-1]}}, imm};
        page    = {page_hi, {PAGE_W{1'b0}}};
        // pair mode: cmp_value already has the ADD immediate taken off
        if (stage.mode)
        begin
            same = (page == stage.cmp_value);
        end
        else
        begin
            same = (page_hi == stage.cmp_value[ADDR_W-1:PAGE_W]);
        end
        hit = stage.present && stage.aligned && is_adrp(stage.adrp_word)
            && stage.pair_ok && same;
    end

endmodule

// ===== rtl/adrp_xref_outq.sv =====
// ----------------------------------------------------------------------------
// adrp_xref_outq
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adrp_xref_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push0,
    input  logic                   push1,
    input  adrp_xref_pkg::result_t data0,
    input  adrp_xref_pkg::result_t data1,
    input  logic                   pop,
    output adrp_xref_pkg::result_t head,
    output logic                   not_empty,
    output logic                   room_two
);
    import adrp_xref_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(OUTQ_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_M2  = CNT_W'(OUTQ_DEPTH - 2);

    result_t            mem [OUTQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_p1;

    always_comb
    begin
        wr_ptr_p1   = wr_ptr_reg + PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem[wr_ptr_reg] <= data0;
        end
        if (push1)
        begin
            mem[wr_ptr_p1] <= data1;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room_two  = (count_reg <= DEPTH_M2);

    `ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_C, "result queue count over depth")
    `ASSERT_IMPLY(a_push_order, push1, push0, "second push without first")
    `ASSERT_IMPLY(a_pop_nonempty, pop, count_reg != '0, "pop from empty result queue")

endmodule

// ===== rtl/arm64_adrp_xref_scanner_core.sv =====
// ----------------------------------------------------------------------------
// arm64_adrp_xref_scanner_core
// ADRP / ADRP+ADD address reference scanner over an instruction word stream.
// ----------------------------------------------------------------------------
// One instruction item is accepted per clock unless in_stall is high. An
// item is captured into a stage register (address add and pair decode), then
// checked from that register (page add and compare) once the output queue has
// room for two results, and its results written to a 4-entry output queue. An
// item that is both a reported match and the region end gives two results,
// popped from the queue one at a time. Input is stalled only while the output
// queue has fewer than two free slots. A base address that is not 4-byte
// aligned suppresses matching and ends the region with an error result.
`include "assert_macros.svh"

module arm64_adrp_xref_scanner_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [adrp_xref_pkg::ADDR_W-1:0]    cfg_data,
    // instruction items
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [adrp_xref_pkg::WORD_W-1:0]    insn_word,
    input  logic                                word_present,
    input  logic                                end_of_region,
    // results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [adrp_xref_pkg::KIND_W-1:0]    result_kind,
    output logic [adrp_xref_pkg::ADDR_W-1:0]    match_address,
    output logic [adrp_xref_pkg::COUNT_W-1:0]   match_count,
    output logic                                last_result
);
    import adrp_xref_pkg::*;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_TARGET = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;
    localparam logic [1:0] CFG_LIMIT  = 2'd3;
    localparam logic [ADDR_W-1:0] WORD_BYTES = ADDR_W'(4);

    // configuration registers
    logic [ADDR_W-1:0]  base_reg;
    logic [ADDR_W-1:0]  target_reg;
    logic               mode_reg;
    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            target_reg <= '0;
            mode_reg   <= 1'b0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE:   base_reg   <= cfg_data;
                CFG_TARGET: target_reg <= cfg_data;
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    // scan position and previous word
    logic [ADDR_W-1:0]  offset_reg, offset_next;
    logic [ADDR_W-1:0]  prev_offset_reg, prev_offset_next;
    logic [WORD_W-1:0]  prev_word_reg, prev_word_next;
    logic               prev_valid_reg, prev_valid_next;

    logic               stage_valid_reg, stage_valid_next;
    stage_t             stage_reg, stage_next;
    logic [COUNT_W-1:0] found_reg, found_next;

    logic               in_accept;
    logic               out_accept;
    logic               stage_fire;
    logic               room_two;
    logic               not_empty;
    logic               hit;
    logic               emit_match;
    logic [COUNT_W-1:0] found_after;
    logic               push0, push1;
    result_t            data0, data1, r_match, r_end, head;
    logic [ADDR_W-1:0]  sel_offset;
    logic               out_is_match;

    assign stage_fire = stage_valid_reg && room_two;
    assign in_stall   = stage_valid_reg && !room_two;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    // capture stage: pick the ADRP candidate and its address
    always_comb
    begin
        sel_offset = mode_reg ? prev_offset_reg : offset_reg;

        stage_next.present   = word_present;
        stage_next.last      = end_of_region;
        stage_next.aligned   = (base_reg[1:0] == 2'b00);
        stage_next.mode      = mode_reg;
        stage_next.adrp_word = mode_reg ? prev_word_reg : insn_word;
        stage_next.pair_ok   = !mode_reg
                             || (prev_valid_reg && add_pair_ok(prev_word_reg, insn_word));
        stage_next.adrp_pc   = base_reg + sel_offset;
        stage_next.cmp_value = mode_reg ? (target_reg - add_imm(insn_word)) : target_reg;

        offset_next      = offset_reg;
        prev_offset_next = prev_offset_reg;
        prev_word_next   = prev_word_reg;
        prev_valid_next  = prev_valid_reg;
        if (in_accept && word_present)
        begin
            prev_offset_next = offset_reg;
            offset_next      = offset_reg + WORD_BYTES;
            prev_word_next   = insn_word;
            prev_valid_next  = 1'b1;
        end
        // region closed: start the next one from scratch
        if (in_accept && end_of_region)
        begin
            offset_next      = '0;
            prev_offset_next = '0;
            prev_word_next   = '0;
            prev_valid_next  = 1'b0;
        end

        if (in_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    adrp_xref_match u_match (
        .stage (stage_reg),
        .hit   (hit)
    );

    // evaluate stage: count, report and close
    always_comb
    begin
        emit_match  = hit && (found_reg < {{(COUNT_W-LIMIT_W){1'b0}}, limit_reg});
        found_after = found_reg;
        if (hit && (found_reg != COUNT_MAX))
        begin
            found_after = found_reg + COUNT_W'(1);
        end

        r_match.kind  = KIND_MATCH;
        r_match.addr  = stage_reg.adrp_pc;
        r_match.count = '0;
        r_match.last  = 1'b0;

        r_end.kind  = stage_reg.aligned ? KIND_DONE : KIND_ERROR;
        r_end.addr  = '0;
        r_end.count = stage_reg.aligned ? found_after : '0;
        r_end.last  = 1'b1;

        push0 = stage_fire && (emit_match || stage_reg.last);
        push1 = stage_fire && emit_match && stage_reg.last;
        data0 = emit_match ? r_match : r_end;
        data1 = r_end;

        found_next = found_reg;
        if (stage_fire)
        begin
            found_next = stage_reg.last ? '0 : found_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            prev_offset_reg <= '0;
            prev_word_reg   <= '0;
            prev_valid_reg  <= 1'b0;
            stage_valid_reg <= 1'b0;
            found_reg       <= '0;
        end
        else
        begin
            offset_reg      <= offset_next;
            prev_offset_reg <= prev_offset_next;
            prev_word_reg   <= prev_word_next;
            prev_valid_reg  <= prev_valid_next;
            stage_valid_reg <= stage_valid_next;
            found_reg       <= found_next;
        end
    end

    // payload only, held until the next accepted item
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_reg <= stage_next;
        end
    end

    adrp_xref_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .data0     (data0),
        .data1     (data1),
        .pop       (out_accept),
        .head      (head),
        .not_empty (not_empty),
        .room_two  (room_two)
    );

    assign out_valid     = not_empty;
    assign result_kind   = head.kind;
    assign match_address = head.addr;
    assign match_count   = head.count;
    assign last_result   = head.last;

    assign out_is_match = out_valid && (result_kind == KIND_MATCH);

    `ASSERT_IMPLY(a_last_kind, out_valid && last_result, result_kind != KIND_MATCH, "end kind")
    `ASSERT_IMPLY(a_match_fields, out_is_match, match_count == '0 && !last_result, "bad match")
    `ASSERT_ALWAYS(a_stall_stage, !in_stall || stage_valid_reg, "stall with empty stage")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for arm64_adrp_xref_scanner_core.
// Streams directed and random instruction regions through the scanner under
// random sender gaps and receiver stalls. Match, count and error results are
// predicted as each item is accepted and compared in order at the output.
// ----------------------------------------------------------------------------
module tb;
    import adrp_xref_pkg::*;

    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;
    localparam logic [1:0] REG_LIMIT  = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              present;
        logic              closing;
    } scan_item_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_RN,
        FLAW_RD,
        FLAW_NARROW,
        FLAW_SHIFT,
        FLAW_IMM,
        FLAW_OPCODE,
        FLAW_GAP,
        FLAW_PAGE
    } pair_flaw_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_write     = 1'b0;
    logic [1:0]          cfg_index     = REG_BASE;
    logic [ADDR_W-1:0]   cfg_data      = '0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [WORD_W-1:0]   insn_word     = '0;
    logic                word_present  = 1'b0;
    logic                end_of_region = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [KIND_W-1:0]   result_kind;
    logic [ADDR_W-1:0]   match_address;
    logic [COUNT_W-1:0]  match_count;
    logic                last_result;

    // register shadow
    logic [ADDR_W-1:0]   base_reg   = '0;
    logic [ADDR_W-1:0]   target_reg = '0;
    logic                pair_mode  = 1'b0;
    logic [LIMIT_W-1:0]  limit_reg  = LIMIT_RESET;

    // scan state of the prediction
    logic [ADDR_W-1:0]   scan_offset = '0;
    logic [WORD_W-1:0]   prev_word   = '0;
    logic                prev_valid  = 1'b0;
    logic [COUNT_W-1:0]  found_count = '0;

    // offset of the next queued word, seen from the item generator
    logic [ADDR_W-1:0]   gen_offset = '0;

    scan_item_t          pending_items[$];
    result_t             expected_results[$];
    scan_item_t          next_item;
    result_t             want;

    int                  items_pushed   = 0;
    int                  items_accepted = 0;
    int                  error_count    = 0;
    int                  burst_left     = 0;
    int                  gap_left       = 0;
    int                  hold_left      = 0;
    int unsigned         rx_cycle       = 0;
    bit                  hold_off_req   = 1'b0;

    arm64_adrp_xref_scanner_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .insn_word     (insn_word),
        .word_present  (word_present),
        .end_of_region (end_of_region),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .match_address (match_address),
        .match_count   (match_count),
        .last_result   (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic adrp_like(input logic [WORD_W-1:0] w);
        return (w & ADRP_MASK) == ADRP_OPC;
    endfunction

    // page reached by an ADRP at pc: signed 21-bit page count on pc's page
    function automatic logic [ADDR_W-1:0] adrp_dest_page(input logic [WORD_W-1:0] w,
                                                         input logic [ADDR_W-1:0] pc);
        logic [ADDR_W-1:0] pages;
        pages = {{43{w[23]}}, w[23:5], w[30:29]};
        return {pc[ADDR_W-1:12], 12'h000} + (pages << 12);
    endfunction

    function automatic void predict_scan(input logic [WORD_W-1:0] word,
                                         input logic present, input logic closing);
        logic              aligned;
        logic              hit;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] hit_pc;
        logic [ADDR_W-1:0] offset;
        result_t           r;
        aligned = (base_reg[1:0] == 2'b00);
        if (present)
        begin
            pc = base_reg + scan_offset;
            hit = 1'b0;
            hit_pc = '0;
            if (aligned && !pair_mode)
            begin
                if (adrp_like(word)
                    && adrp_dest_page(word, pc) == {target_reg[ADDR_W-1:12], 12'h000})
                begin
                    hit = 1'b1;
                    hit_pc = pc;
                end
            end
            else if (aligned && prev_valid && adrp_like(prev_word))
            begin
                // 64-bit ADD immediate, shift 0 or 12, Rd = Rn = ADRP's Rd
                if ((word & ADDI_MASK) == ADDI_OPC && word[31] && word[23:22] < 2'd2
                    && word[4:0] == prev_word[4:0] && word[9:5] == prev_word[4:0])
                begin
                    offset = {52'd0, word[21:10]};
                    if (word[22])
                    begin
                        offset = offset << 12;
                    end
                    if (adrp_dest_page(prev_word, pc - 64'd4) + offset == target_reg)
                    begin
                        hit = 1'b1;
                        hit_pc = pc - 64'd4;
                    end
                end
            end
            if (hit)
            begin
                if (found_count < {{(COUNT_W-LIMIT_W){1'b0}}, limit_reg})
                begin
                    r.kind = KIND_MATCH;
                    r.addr = hit_pc;
                    r.count = '0;
                    r.last = 1'b0;
                    expected_results.push_back(r);
                end
                if (found_count != COUNT_MAX)
                begin
                    found_count = found_count + COUNT_W'(1);
                end
            end
            prev_word = word;
            prev_valid = 1'b1;
            scan_offset = scan_offset + 64'd4;
        end
        if (closing)
        begin
            r.kind = aligned ? KIND_DONE : KIND_ERROR;
            r.addr = '0;
            r.count = aligned ? found_count : '0;
            r.last = 1'b1;
            expected_results.push_back(r);
            scan_offset = '0;
            prev_word = '0;
            prev_valid = 1'b0;
            found_count = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of items with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_scan(insn_word, word_present, end_of_region);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (burst_left == 0)
                begin
                    // some bursts run back to back with no gap at all
                    if ($urandom_range(0, 3) == 0)
                    begin
                        gap_left = 0;
                        burst_left = $urandom_range(20, 60);
                    end
                    else
                    begin
                        gap_left = $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 12);
                    end
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    insn_word <= next_item.word;
                    word_present <= next_item.present;
                    end_of_region <= next_item.closing;
                    in_valid <= 1'b1;
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern chosen by rx_cycle bits 7:6, plus hold-offs
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_style_t'(rx_cycle[7:6]))
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_COIN:     out_stall <= $urandom_range(0, 1);
                    STALL_PERIODIC: out_stall <= (rx_cycle % 5) < 3;
                    default:        out_stall <= $urandom_range(0, 9) < 8;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string field,
                                        input logic [ADDR_W-1:0] want_v,
                                        input logic [ADDR_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, field, want_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual kind %0d addr %h count %0d",
                         $time, result_kind, match_address, match_count);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", ADDR_W'(want.kind), ADDR_W'(result_kind));
                check_field("match_address", want.addr, match_address);
                check_field("match_count", ADDR_W'(want.count), ADDR_W'(match_count));
                check_field("last_result", ADDR_W'(want.last), ADDR_W'(last_result));
            end
        end
    end

    // ------------------------------------------------------------------
    // Item generation
    // ------------------------------------------------------------------
    function automatic void push_item(input logic [WORD_W-1:0] word, input logic present,
                                      input logic closing);
        pending_items.push_back('{word: word, present: present, closing: closing});
        items_pushed++;
        if (present)
        begin
            gen_offset = gen_offset + 64'd4;
        end
        if (closing)
        begin
            gen_offset = '0;
        end
    endfunction

    function automatic logic [20:0] pages_between(input logic [ADDR_W-1:0] pc,
                                                  input logic [ADDR_W-1:0] addr);
        logic [51:0] span;
        span = addr[ADDR_W-1:12] - pc[ADDR_W-1:12];
        return span[20:0];
    endfunction

    function automatic logic [WORD_W-1:0] adrp_word(input logic [4:0] rd,
                                                    input logic [20:0] pages);
        return {1'b1, pages[1:0], ADRP_OPC[28:24], pages[20:2], rd};
    endfunction

    function automatic logic [WORD_W-1:0] add_word(input logic [4:0] rd, input logic [4:0] rn,
                                                   input logic shift12, input logic [11:0] imm12);
        return {1'b1, ADDI_OPC[30:24], 1'b0, shift12, imm12, rn, rd};
    endfunction

    // ADRP aimed at the target page from the next word's address
    function automatic void push_page_ref(input logic closing);
        push_item(adrp_word(5'($urandom_range(0, 31)),
                            pages_between(base_reg + gen_offset, target_reg)), 1'b1, closing);
    endfunction

    // ADRP + ADD aimed at the exact target, optionally broken in one way
    function automatic void push_pair_ref(input logic shift12, input pair_flaw_t flaw,
                                          input logic closing);
        logic [4:0]        rd;
        logic [11:0]       imm12;
        logic [ADDR_W-1:0] dest;
        logic [20:0]       pages;
        logic [WORD_W-1:0] add_code;
        int                bit_pos;
        rd = 5'($urandom_range(0, 31));
        imm12 = shift12 ? 12'($urandom) : target_reg[11:0];
        dest = shift12 ? target_reg - {40'd0, imm12, 12'd0} : target_reg;
        pages = pages_between(base_reg + gen_offset, dest);
        if (flaw == FLAW_PAGE)
        begin
            pages = pages + 21'd1;
        end
        add_code = add_word(rd, rd, shift12, imm12);
        bit_pos = $urandom_range(24, 30);
        case (flaw)
            FLAW_RN:     add_code[9:5] = ~rd;
            FLAW_RD:     add_code[4:0] = ~rd;
            FLAW_NARROW: add_code[31] = 1'b0;
            FLAW_SHIFT:  add_code[23] = 1'b1;
            FLAW_IMM:    add_code[21:10] = imm12 + 12'd1;
            FLAW_OPCODE: add_code[bit_pos] = ~add_code[bit_pos];
            default:     ;
        endcase
        push_item(adrp_word(rd, pages), 1'b1, 1'b0);
        if (flaw == FLAW_GAP)
        begin
            push_item($urandom, 1'b1, 1'b0);
        end
        push_item(add_code, 1'b1, closing);
    endfunction

    // ------------------------------------------------------------------
    // Configuration and sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] index, input logic [ADDR_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            REG_BASE:   base_reg = value;
            REG_TARGET: target_reg = value;
            REG_MODE:   pair_mode = value[0];
            default:    limit_reg = value[LIMIT_W-1:0];
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] target,
                             input logic mode, input logic [LIMIT_W-1:0] limit);
        write_reg(REG_BASE, base);
        write_reg(REG_TARGET, target);
        write_reg(REG_MODE, {63'd0, mode});
        write_reg(REG_LIMIT, {48'd0, limit});
    endtask

    // wait until every item is accepted and every result is back, then let in-flight items settle
    task automatic wait_drained;
        while (items_accepted != items_pushed || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  target;
        logic [30:0]        spread;
        logic [LIMIT_W-1:0] limit;
        case ($urandom_range(0, 9))
            0:       base = {$urandom, $urandom};
            1:       base = 64'hFFFF_FFFF_FFFF_FFFC - 64'(4 * $urandom_range(0, 16));
            2:       base = 64'(4 * $urandom_range(0, 16));
            default: base = {$urandom, $urandom} & ~64'h3;
        endcase
        spread = 31'($urandom);
        case ($urandom_range(0, 9))
            0:       target = {$urandom, $urandom};
            1:       target = '0;
            2:       target = '1;
            default: target = base + {{33{spread[30]}}, spread};
        endcase
        // page-aligned targets let shifted ADD pairs hit
        if ($urandom_range(0, 2) == 0)
        begin
            target[11:0] = '0;
        end
        case ($urandom_range(0, 7))
            0:       limit = 16'd0;
            1:       limit = 16'd1;
            2:       limit = 16'd2;
            3:       limit = 16'($urandom);
            default: limit = 16'hFFFF;
        endcase
        configure(base, target, 1'($urandom_range(0, 1)), limit);
    endtask

    task automatic random_region_items(input int n_items);
        int                sel;
        logic              closing;
        logic [WORD_W-1:0] w;
        for (int n = 0; n < n_items; n++)
        begin
            sel = $urandom_range(0, 99);
            closing = ($urandom_range(0, 11) == 0);
            if (sel < 40)
            begin
                if (pair_mode)
                begin
                    push_pair_ref(1'($urandom_range(0, 1)), FLAW_NONE, closing);
                end
                else
                begin
                    push_page_ref(closing);
                end
            end
            else if (sel < 55)
            begin
                push_pair_ref(1'($urandom_range(0, 1)),
                              pair_flaw_t'($urandom_range(FLAW_RN, FLAW_PAGE)), closing);
            end
            else if (sel < 65)
            begin
                w = $urandom;
                w[31] = 1'b1;
                w[28:24] = ADRP_OPC[28:24];
                push_item(w, 1'b1, closing);
            end
            else if (sel < 92)
            begin
                push_item($urandom, 1'b1, closing);
            end
            else
            begin
                push_item($urandom, 1'b0, closing);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // page mode from address zero: empty region, immediate extremes, plain words
        configure(64'h0, 64'h0000_0000_0000_0ABC, 1'b0, 16'hFFFF);
        push_item(32'h0, 1'b0, 1'b1);
        push_page_ref(1'b0);
        push_item(adrp_word(5'd31, 21'h0F_FFFF), 1'b1, 1'b0);
        push_item(adrp_word(5'd0, 21'h10_0000), 1'b1, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(32'h0000_0000, 1'b1, 1'b0);
        push_item(32'h0, 1'b0, 1'b0);
        push_page_ref(1'b1);

        // region that wraps past the top of the address space, report limit one
        wait_drained();
        configure(64'hFFFF_FFFF_FFFF_FFF0, 64'h0000_0000_0000_0010, 1'b0, 16'd1);
        repeat (5) push_page_ref(1'b0);
        push_page_ref(1'b1);

        // pair mode, all-ones target, report limit zero; ADRP as last word,
        // then a lone ADD opening the next region
        wait_drained();
        configure(64'h0000_0000_4000_0000, '1, 1'b1, 16'd0);
        push_pair_ref(1'b0, FLAW_NONE, 1'b0);
        push_pair_ref(1'b1, FLAW_NONE, 1'b0);
        push_item(adrp_word(5'd7, pages_between(base_reg + gen_offset, target_reg)), 1'b1, 1'b1);
        push_item(add_word(5'd7, 5'd7, 1'b0, 12'hFFF), 1'b1, 1'b1);

        // misaligned base ends with an error
        wait_drained();
        configure('1, 64'h0, 1'b0, 16'hFFFF);
        push_page_ref(1'b0);
        push_item($urandom, 1'b1, 1'b1);

        for (int p = 0; p < 20; p++)
        begin
            wait_drained();
            random_config();
            // long receiver hold-off while the sender keeps offering items
            if (p == 2)
            begin
                hold_off_req = 1'b1;
            end
            random_region_items($urandom_range(15, 24));
        end
        push_item($urandom, 1'b1, 1'b1);
        wait_drained();

        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
